// ===== hdl/gfla_pkg.sv =====
`timescale 1ns / 1ps

package gfla_pkg;

    localparam int ELEM_BITS = 8;
    localparam int POLY_BITS = ELEM_BITS + 1;
    localparam int FB_BITS   = 4;
    localparam logic [FB_BITS-1:0] FIELD_BITS_RESET = 4'd2;

    localparam logic [1:0] MODE_ANTILOG = 2'd0;
    localparam logic [1:0] MODE_LOG     = 2'd1;
    localparam logic [1:0] MODE_INVERSE = 2'd2;

    localparam logic [1:0] STAT_OK          = 2'd0;
    localparam logic [1:0] STAT_ZERO        = 2'd1;
    localparam logic [1:0] STAT_RANGE       = 2'd2;
    localparam logic [1:0] STAT_UNSUPPORTED = 2'd3;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ELEM_BITS-1:0] operand;
    } in_item_t;

    typedef struct packed {
        logic [ELEM_BITS-1:0] result;
        logic [1:0]           status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOG  = 4'b0010,
        S_ANTI = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    // Primitive polynomial with the leading term; zero marks an unsupported degree.
    function automatic logic [POLY_BITS-1:0] poly_for(input logic [FB_BITS-1:0] m);
        logic [POLY_BITS-1:0] p;
        case (m)
            4'd2:    p = 9'h007;
            4'd3:    p = 9'h00B;
            4'd4:    p = 9'h013;
            4'd5:    p = 9'h025;
            4'd6:    p = 9'h043;
            4'd8:    p = 9'h11D;
            default: p = 9'h000;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/gf2m_log_antilog_inverse_core.sv =====
`timescale 1ns / 1ps
// An antilog of e steps alpha's power e times; a log steps through powers of alpha until it
// meets the operand; an inverse finds the log l, then the antilog of 2^m - 1 - l (0 if l = 0).
// An error answer is ready for transfer in the cycle after its input transfer.
// The core takes one item at a time: in_ready returns in the cycle after the result
// transfer.
// Reset (rst_n, asynchronous, active low) returns to idle and sets field_bits to 2.
module gf2m_log_antilog_inverse_core #(
    parameter int MAX_FIELD_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  gfla_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gfla_pkg::out_item_t out_data
);
    import gfla_pkg::*;

    logic [FB_BITS-1:0]   field_bits_reg;
    state_t               state_reg, state_next;
    logic [ELEM_BITS-1:0] x_reg, x_next;
    logic [ELEM_BITS-1:0] cnt_reg, cnt_next;
    logic [ELEM_BITS-1:0] v_reg, v_next;
    logic [1:0]           mode_reg, mode_next;
    logic [FB_BITS-1:0]   m_reg, m_next;
    logic [POLY_BITS-1:0] poly_reg, poly_next;
    logic [ELEM_BITS-1:0] q1_reg, q1_next;
    out_item_t            out_reg, out_next;

    logic [POLY_BITS-1:0] cur_poly;
    logic [POLY_BITS-1:0] cur_q;
    logic [POLY_BITS-1:0] cur_q1;
    logic                 supported;
    logic [ELEM_BITS-1:0] step_y;

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {{(32-FB_BITS){1'b0}}, field_bits_reg} : 32'd0;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = out_reg;

    assign cur_poly  = poly_for(field_bits_reg);
    assign supported = (cur_poly != '0) && (int'(field_bits_reg) <= MAX_FIELD_BITS);
    assign cur_q     = POLY_BITS'(1) << field_bits_reg;
    assign cur_q1    = cur_q - POLY_BITS'(1);

    gfla_alpha_step u_step (
        .x    (x_reg),
        .m    (m_reg),
        .poly (poly_reg),
        .y    (step_y)
    );

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        mode_next  = mode_reg;
        m_next     = m_reg;
        poly_next  = poly_reg;
        q1_next    = q1_reg;
        out_next   = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    m_next          = field_bits_reg;
                    poly_next       = cur_poly;
                    q1_next         = cur_q1[ELEM_BITS-1:0];
                    mode_next       = in_data.mode;
                    v_next          = in_data.operand;
                    x_next          = ELEM_BITS'(1);
                    out_next.result = '0;
                    out_next.status = STAT_OK;
                    if (!supported)
                    begin
                        out_next.status = STAT_UNSUPPORTED;
                        state_next      = S_DONE;
                    end
                    else if (in_data.mode == MODE_ANTILOG)
                    begin
                        cnt_next = in_data.operand;
                        if ({1'b0, in_data.operand} >= cur_q1)
                        begin
                            out_next.status = STAT_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ANTI;
                        end
                    end
                    else if (in_data.mode == MODE_LOG || in_data.mode == MODE_INVERSE)
                    begin
                        cnt_next = '0;
                        if (in_data.operand == '0)
                        begin
                            out_next.status = STAT_ZERO;
                            state_next      = S_DONE;
                        end
                        else if ({1'b0, in_data.operand} >= cur_q)
                        begin
                            out_next.status = STAT_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LOG;
                        end
                    end
                    else
                    begin
                        out_next.status = STAT_RANGE;
                        state_next      = S_DONE;
                    end
                end
            end
            S_LOG:
            begin
                if (x_reg == v_reg)
                begin
                    if (mode_reg == MODE_LOG)
                    begin
                        out_next.result = cnt_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cnt_next   = (cnt_reg == '0) ? '0 : q1_reg - cnt_reg;
                        x_next     = ELEM_BITS'(1);
                        state_next = S_ANTI;
                    end
                end
                else
                begin
                    x_next   = step_y;
                    cnt_next = cnt_reg + ELEM_BITS'(1);
                end
            end
            S_ANTI:
            begin
                if (cnt_reg == '0)
                begin
                    out_next.result = x_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    x_next   = step_y;
                    cnt_next = cnt_reg - ELEM_BITS'(1);
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            field_bits_reg <= FIELD_BITS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr[2] == 1'b0)
            begin
                field_bits_reg <= pwdata[FB_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        cnt_reg  <= cnt_next;
        v_reg    <= v_next;
        mode_reg <= mode_next;
        m_reg    <= m_next;
        poly_reg <= poly_next;
        q1_reg   <= q1_next;
        out_reg  <= out_next;
    end

`ifndef SYNTHESIS
    a_err_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != STAT_OK) |-> (out_data.result == '0))
        else $error("error transfer carries a nonzero result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted transfer");

    a_log_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOG) |-> (cnt_reg < q1_reg))
        else $error("log search ran past the field order");

    a_anti_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ANTI || state_reg == S_LOG) |-> (x_reg != '0))
        else $error("power of alpha became zero");
`endif

endmodule

// ===== hdl/gfla_alpha_step.sv =====
`timescale 1ns / 1ps

module gfla_alpha_step (
    input  logic [gfla_pkg::ELEM_BITS-1:0] x,
    input  logic [gfla_pkg::FB_BITS-1:0]   m,
    input  logic [gfla_pkg::POLY_BITS-1:0] poly,
    output logic [gfla_pkg::ELEM_BITS-1:0] y
);
    import gfla_pkg::*;

    logic [POLY_BITS-1:0] shifted;
    logic [POLY_BITS-1:0] reduced;

    always_comb
    begin
        shifted = {x, 1'b0};
        if (m <= FB_BITS'(ELEM_BITS) && shifted[m])
        begin
            reduced = shifted ^ poly;
        end
        else
        begin
            reduced = shifted;
        end
        y = reduced[ELEM_BITS-1:0];
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import gfla_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] FIELD_BITS_ADDR = 3'd0;
    localparam int unsigned CYCLE_LIMIT = 2_500_000;
    localparam int unsigned PLAN_LEN = 13;

    localparam logic [POLY_BITS-1:0] PRIM_POLY [16] = '{
        9'h000, 9'h000, 9'h007, 9'h00B, 9'h013, 9'h025, 9'h043, 9'h000,
        9'h11D, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000
    };

    localparam int unsigned PLAN_BITS [PLAN_LEN] = '{
        2, 3, 4, 5, 6, 8, 7, 0, 15, 9, 8, 1, 4
    };
    localparam int unsigned PLAN_ITEMS [PLAN_LEN] = '{
        60, 60, 80, 80, 100, 220, 25, 25, 25, 25, 120, 25, 60
    };

    class gf_answer_book;
        out_item_t             pending_answers[$];
        logic [FB_BITS-1:0]    field_bits;
        logic [ELEM_BITS-1:0]  alpha_pow [256];
        logic [ELEM_BITS-1:0]  discrete_log [256];
        int unsigned           errors;
        int unsigned           checked;
        int unsigned           status_seen [4];

        function void set_field_bits(input logic [FB_BITS-1:0] m);
            logic [POLY_BITS-1:0] x;
            int unsigned k;
            field_bits = m;
            x = 1;
            if (PRIM_POLY[m] != '0)
            begin
                for (k = 0; k < (1 << m) - 1; k++)
                begin
                    alpha_pow[k] = x[ELEM_BITS-1:0];
                    discrete_log[x[ELEM_BITS-1:0]] = k[ELEM_BITS-1:0];
                    x = x << 1;
                    if (x[m])
                    begin
                        x = x ^ PRIM_POLY[m];
                    end
                end
            end
        endfunction

        function out_item_t answer_for(input in_item_t op);
            out_item_t a;
            int unsigned q;
            int unsigned l;
            a.result = '0;
            a.status = STAT_OK;
            if (PRIM_POLY[field_bits] == '0)
            begin
                a.status = STAT_UNSUPPORTED;
            end
            else
            begin
                q = 1 << field_bits;
                case (op.mode)
                    MODE_ANTILOG:
                    begin
                        if (op.operand >= q - 1)
                            a.status = STAT_RANGE;
                        else
                            a.result = alpha_pow[op.operand];
                    end
                    MODE_LOG, MODE_INVERSE:
                    begin
                        if (op.operand == 0)
                        begin
                            a.status = STAT_ZERO;
                        end
                        else if (op.operand >= q)
                        begin
                            a.status = STAT_RANGE;
                        end
                        else
                        begin
                            l = discrete_log[op.operand];
                            if (op.mode == MODE_LOG)
                                a.result = l[ELEM_BITS-1:0];
                            else
                                a.result = alpha_pow[(q - 1 - l) % (q - 1)];
                        end
                    end
                    default:
                    begin
                        a.status = STAT_RANGE;
                    end
                endcase
            end
            return a;
        endfunction

        function void note_operand(input in_item_t op);
            pending_answers.push_back(answer_for(op));
        endfunction

        function void check_answer(input out_item_t got);
            out_item_t want;
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer, result=%0h status=%0d",
                         $time, got.result, got.status);
                return;
            end
            want = pending_answers.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.result !== want.result)
            begin
                errors++;
                $display("%0t: result field: expected %0h, actual %0h",
                         $time, want.result, got.result);
            end
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status field: expected %0d, actual %0d",
                         $time, want.status, got.status);
            end
        endfunction

        function int unsigned pending();
            return pending_answers.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    gf_answer_book book = new();
    int unsigned   cycles = 0;
    int unsigned   burst_left = 0;
    int unsigned   stall_run = 0;
    int unsigned   settings_done = 0;

    gf2m_log_antilog_inverse_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles.", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                book.note_operand(in_data);
            if (out_valid && out_ready)
                book.check_answer(out_data);
        end
    end

    // The receiver cycles through four stall styles, chosen by bits 9:8 of the cycle count.
    always @(posedge clk)
    begin
        if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((cycles >> 8) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        stall_run <= $urandom_range(5, 20);
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic [ELEM_BITS-1:0] opnd);
        in_item_t op;
        int unsigned gap;
        op.mode = mode;
        op.operand = opnd;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_data  <= op;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(input logic [FB_BITS-1:0] m);
        logic [1:0] mode;
        logic [ELEM_BITS-1:0] opnd;
        mode = ($urandom_range(0, 15) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        if (PRIM_POLY[m] != '0 && $urandom_range(0, 9) < 8)
            opnd = 8'($urandom_range(0, (1 << m) - 1));
        else
            opnd = 8'($urandom_range(0, 255));
        send_item(mode, opnd);
    endtask

    task automatic wait_all_answered();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (book.pending() != 0);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            book.errors++;
            $display("%0t: field_bits readback: expected %0h, actual %0h",
                     $time, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_field(input logic [FB_BITS-1:0] m);
        wait_all_answered();
        repeat (4) @(posedge clk);
        reg_write(FIELD_BITS_ADDR, 32'(m));
        book.set_field_bits(m);
        reg_check(FIELD_BITS_ADDR, 32'(m));
        settings_done++;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        book.set_field_bits(FIELD_BITS_RESET);
        @(posedge clk);
        reg_check(FIELD_BITS_ADDR, 32'(FIELD_BITS_RESET));

        send_item(MODE_ANTILOG, 8'd0);
        send_item(MODE_ANTILOG, 8'd2);
        send_item(MODE_ANTILOG, 8'd3);
        send_item(MODE_LOG, 8'd3);
        send_item(MODE_LOG, 8'd4);
        send_item(MODE_INVERSE, 8'd2);
        send_item(MODE_INVERSE, 8'd0);
        send_item(MODE_UNUSED, 8'd0);

        set_field(4'd8);
        send_item(MODE_ANTILOG, 8'd0);
        send_item(MODE_ANTILOG, 8'd1);
        send_item(MODE_ANTILOG, 8'd254);
        send_item(MODE_ANTILOG, 8'd255);
        send_item(MODE_LOG, 8'd1);
        send_item(MODE_LOG, 8'd2);
        send_item(MODE_LOG, 8'd255);
        send_item(MODE_LOG, 8'd0);
        send_item(MODE_INVERSE, 8'd1);
        send_item(MODE_INVERSE, 8'd255);
        send_item(MODE_INVERSE, 8'd0);
        send_item(MODE_INVERSE, 8'h8E);
        send_item(MODE_UNUSED, 8'hFF);
        send_item(MODE_UNUSED, 8'd0);

        for (int p = 0; p < PLAN_LEN; p++)
        begin
            set_field(4'(PLAN_BITS[p]));
            for (int k = 0; k < PLAN_ITEMS[p]; k++)
            begin
                if (k == PLAN_ITEMS[p] / 2 || $urandom_range(0, 199) == 0)
                    wait_all_answered();
                send_random(4'(PLAN_BITS[p]));
            end
        end

        wait_all_answered();
        repeat (20) @(posedge clk);
        if (book.pending() != 0)
        begin
            book.errors++;
            $display("%0t: %0d expected results never arrived", $time, book.pending());
        end
        $display("Checked %0d transfers across %0d field_bits writes, extremes included.",
                 book.checked, settings_done);
        $display("Status mix: ok %0d, zero operand %0d, out of range %0d, unsupported %0d.",
                 book.status_seen[0], book.status_seen[1], book.status_seen[2],
                 book.status_seen[3]);
        if (book.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/gfla_pkg.sv
hdl/gfla_alpha_step.sv
hdl/gf2m_log_antilog_inverse_core.sv
tb/tb_top.sv
